// File: rtl/mrq_pkg.sv
package mrq_pkg;

    localparam int LEVELS  = 8;
    localparam int DEPTH   = 16;
    localparam int ID_BITS = 6;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOTS  = LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int PRIO_W = 4;
    localparam int CAP_W  = 3;
    localparam int OLVL_W = 3;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_NOT_RUNNABLE = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_BAD_PRIO     = 3'd4
    } status_t;

    typedef struct packed {
        logic               valid;
        logic               req_type;
        logic [ID_BITS-1:0] proc_id;
        logic [PRIO_W-1:0]  priority_req;
        logic               is_runnable;
        logic               clamp_mode;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [OLVL_W-1:0]  out_level;
        logic               pop;
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [ID_BITS-1:0] wdata;
    } dec_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] ptr);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(lvl) * ADDR_W'(DEPTH) + ADDR_W'(ptr);
        return a;
    endfunction

endpackage

// File: rtl/mrq_ram.sv
module mrq_ram #(
    parameter int WORD_W = 8,
    parameter int WORDS  = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(WORDS)-1:0]  waddr,
    input  logic [WORD_W-1:0]         wdata,
    input  logic                      re,
    input  logic [$clog2(WORDS)-1:0]  raddr,
    output logic [WORD_W-1:0]         rdata
);

    logic [WORD_W-1:0] mem_reg [WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mrq_ctrl.sv
module mrq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mrq_pkg::req_t               req,
    input  logic [mrq_pkg::CAP_W-1:0]   clamp_cap,
    output mrq_pkg::dec_t               dec
);
    import mrq_pkg::*;

    logic [PTR_W-1:0]  head_reg  [LEVELS];
    logic [PTR_W-1:0]  tail_reg  [LEVELS];
    logic [PTR_W-1:0]  head_next [LEVELS];
    logic [PTR_W-1:0]  tail_next [LEVELS];
    logic [LEVELS-1:0] nonempty;
    logic [PRIO_W-1:0] prio_eff;
    logic              prio_bad;
    logic [LVL_W-1:0]  enq_lvl;
    logic [LVL_W-1:0]  deq_lvl;
    logic              full;

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            nonempty[i] = head_reg[i] != tail_reg[i];
        end
    end

    always_comb
    begin
        deq_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                deq_lvl = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        if (req.clamp_mode && (req.priority_req > PRIO_W'(clamp_cap)))
            prio_eff = PRIO_W'(clamp_cap);
        else
            prio_eff = req.priority_req;
        prio_bad = int'(prio_eff) >= LEVELS;
        enq_lvl  = LVL_W'(prio_eff);
        full     = ptr_inc(tail_reg[enq_lvl]) == head_reg[enq_lvl];
    end

    always_comb
    begin
        dec           = '0;
        dec.status    = ST_OK;
        dec.wdata     = req.proc_id;
        if (req.valid)
        begin
            if (req.req_type == REQ_ENQ)
            begin
                if (!req.is_runnable)
                    dec.status = ST_NOT_RUNNABLE;
                else if (prio_bad)
                    dec.status = ST_BAD_PRIO;
                else if (full)
                    dec.status = ST_FULL;
                else
                begin
                    dec.we        = 1'b1;
                    dec.out_level = OLVL_W'(enq_lvl);
                    dec.addr      = slot_addr(enq_lvl, tail_reg[enq_lvl]);
                end
            end
            else
            begin
                if (nonempty == '0)
                    dec.status = ST_EMPTY;
                else
                begin
                    dec.pop       = 1'b1;
                    dec.out_level = OLVL_W'(deq_lvl);
                    dec.addr      = slot_addr(deq_lvl, head_reg[deq_lvl]);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
        end
        if (dec.we)
            tail_next[enq_lvl] = ptr_inc(tail_reg[enq_lvl]);
        if (dec.pop)
            head_next[deq_lvl] = ptr_inc(head_reg[deq_lvl]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_write_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(dec.we && dec.pop))
        else $error("write and pop in one cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        dec.pop |-> (head_reg[deq_lvl] != tail_reg[deq_lvl]))
        else $error("pop from empty level");

    a_enq_fills: assert property (@(posedge clk) disable iff (!rst_n)
        dec.we |=> nonempty[$past(enq_lvl)])
        else $error("level empty after enqueue");

    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (dec.status != ST_OK) |-> (!dec.we && !dec.pop && dec.out_level == '0))
        else $error("failed request touched state");
`endif

endmodule

// File: rtl/multilevel_ready_queue_unit.sv
// Pipeline: an accepted word is registered in req_reg and decided from it; done,
// status, out_level and the slot read data are registered from that decision.
// Throughput: one word per cycle while busy is low; pointer update and slot write/read
// are done in the single decision stage and the slot read adds the second register.
// Reset (rst_n low, async): all levels empty, clamp_cap = 7, busy high for one cycle.
// The receiver cannot stall: every result is shown exactly once.
module multilevel_ready_queue_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [mrq_pkg::ID_BITS-1:0]   proc_id,
    input  logic [mrq_pkg::PRIO_W-1:0]    priority_req,
    input  logic                          is_runnable,
    input  logic                          clamp_mode,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mrq_pkg::CAP_W-1:0]     cfg_data,
    output logic                          done,
    output logic [2:0]                    status,
    output logic [mrq_pkg::ID_BITS-1:0]   out_proc_id,
    output logic [mrq_pkg::OLVL_W-1:0]    out_level
);
    import mrq_pkg::*;

    logic              busy_reg;
    logic [CAP_W-1:0]  clamp_cap_reg;
    req_t              req_reg;
    req_t              req_next;
    dec_t              dec;
    logic              done_reg;
    logic              pop_reg;
    status_t           status_reg;
    logic [OLVL_W-1:0] level_reg;
    logic [ID_BITS-1:0] rdata;
    logic              accept;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    always_comb
    begin
        req_next              = req_reg;
        req_next.valid        = accept;
        if (accept)
        begin
            req_next.req_type     = req_type;
            req_next.proc_id      = proc_id;
            req_next.priority_req = priority_req;
            req_next.is_runnable  = is_runnable;
            req_next.clamp_mode   = clamp_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            clamp_cap_reg <= CAP_W'(7);
            req_reg       <= '0;
            done_reg      <= 1'b0;
            pop_reg       <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                clamp_cap_reg <= cfg_data;
            req_reg  <= req_next;
            done_reg <= req_reg.valid;
            pop_reg  <= dec.pop;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= dec.status;
        level_reg  <= dec.out_level;
    end

    mrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_reg),
        .clamp_cap (clamp_cap_reg),
        .dec       (dec)
    );

    mrq_ram #(
        .WORD_W (ID_BITS),
        .WORDS  (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (dec.we),
        .waddr (dec.addr),
        .wdata (dec.wdata),
        .re    (dec.pop),
        .raddr (dec.addr),
        .rdata (rdata)
    );

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_level   = level_reg;
    assign out_proc_id = pop_reg ? rdata : '0;

`ifndef ASSERT_OFF
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted word gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without request");

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        pop_reg |-> (done && status_reg == ST_OK))
        else $error("pop without ok result");
`endif

endmodule
